>>> hdl/qte_pkg.sv
`timescale 1ns / 1ps

package qte_pkg;

  // number formats
  localparam int TIME_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int VSHIFT       = 31 - FRAC_BITS;
  localparam int VNUM_W       = 64 - VSHIFT;
  localparam int VDIV_W       = VNUM_W + (VNUM_W % 2);
  localparam int VDIV_STAGES  = VDIV_W / 2;
  localparam int PHASE_STAGES = 16;

  localparam logic [31:0] TIME_MASK = (TIME_BITS >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [47:0] VEL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] VEL_MIN = 48'h8000_0000_0000;
  localparam logic [32:0] H_ONE   = 33'h1_0000_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_X_START     = 3'd0,
    REG_X_END       = 3'd1,
    REG_Y_START     = 3'd2,
    REG_Y_END       = 3'd3,
    REG_Z_START     = 3'd4,
    REG_Z_END       = 3'd5,
    REG_ANGLE_TOTAL = 3'd6,
    REG_DURATION    = 3'd7
  } reg_idx_t;

  // control that travels with each request
  typedef struct packed {
    logic valid;
    logic past;
  } ctl_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [1:0]  q;
  } div2_t;

  // two restoring division steps, partial remainder stays below divisor
  function automatic div2_t div_step2(logic [31:0] rem, logic [1:0] bits,
                                      logic [31:0] dvs);
    logic [32:0] a;
    logic [32:0] b;
    div2_t       res;
    a = {rem, bits[1]};
    if (a >= {1'b0, dvs}) begin
      a = a - {1'b0, dvs};
      res.q[1] = 1'b1;
    end else begin
      res.q[1] = 1'b0;
    end
    b = {a[31:0], bits[0]};
    if (b >= {1'b0, dvs}) begin
      b = b - {1'b0, dvs};
      res.q[0] = 1'b1;
    end else begin
      res.q[0] = 1'b0;
    end
    res.rem = b[31:0];
    return res;
  endfunction

  // q0.32 product, round half up
  function automatic logic [31:0] mulq(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + 64'h8000_0000;
    return p[63:32];
  endfunction

endpackage

>>> hdl/qte_phase.sv
`timescale 1ns / 1ps

module qte_phase (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [31:0]    t,
  input  logic [31:0]    dur,
  output qte_pkg::ctl_t  ctl_out,
  output logic [31:0]    s,
  output logic           at_end
);

  localparam int N = qte_pkg::PHASE_STAGES;

  logic              vld  [0:N];
  logic              pst  [0:N];
  logic              aend [0:N];
  logic [31:0]       rem  [0:N];
  logic [31:0]       quo  [0:N];
  qte_pkg::div2_t    step [0:N-1];

  // two quotient bits of t * 2^32 / dur per stage
  always_comb begin
    for (int k = 0; k < N; k++) begin
      step[k] = qte_pkg::div_step2(rem[k], 2'b00, dur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 0; k < N; k++) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pst[0]  <= t > dur;
      aend[0] <= t >= dur;
      rem[0]  <= (t >= dur) ? 32'd0 : t;
      quo[0]  <= '0;
      for (int k = 0; k < N; k++) begin
        pst[k+1]  <= pst[k];
        aend[k+1] <= aend[k];
        rem[k+1]  <= step[k].rem;
        quo[k+1]  <= {quo[k][29:0], step[k].q};
      end
    end
  end

  assign ctl_out.valid = vld[N];
  assign ctl_out.past  = pst[N];
  assign s             = quo[N];
  assign at_end        = aend[N];

endmodule

>>> hdl/qte_poly.sv
`timescale 1ns / 1ps

module qte_poly (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  qte_pkg::ctl_t  ctl_in,
  input  logic [31:0]    s_in,
  input  logic           at_end_in,
  output qte_pkg::ctl_t  ctl_out,
  output logic [32:0]    h,
  output logic [31:0]    g
);

  qte_pkg::ctl_t c1, c2, c3, c4, c5;
  logic [31:0]   s1, s2_1, s2, s3_2, s3, s4_3, s3_3, s3_4, s4_4, s5_4;
  logic          e1, e2, e3, e4;
  logic [30:0]   w1;
  logic [27:0]   w2_2;
  logic [31:0]   g3, g4;
  logic [32:0]   h5;
  logic [31:0]   g5;

  logic [63:0]   wprod;
  logic [61:0]   wsq;
  logic [37:0]   hs;
  logic          hs_over;

  // s*(1-s) for the velocity shape, squared one stage later
  always_comb begin
    wprod   = 64'(s_in) * 64'(qte_pkg::H_ONE - {1'b0, s_in}) + 64'h8000_0000;
    wsq     = 62'(w1) * 62'(w1) + 62'h1_0000_0000;
    hs      = 38'(s3_4) * 38'd10 - 38'(s4_4) * 38'd15 + 38'(s5_4) * 38'd6;
    hs_over = !hs[37] && (hs[36:0] > 37'(qte_pkg::H_ONE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
    end else if (en) begin
      c1 <= ctl_in;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      c5 <= c4;
    end
  end

  // power chain s^2 .. s^5, one multiply per stage
  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= s_in;
      e1   <= at_end_in;
      s2_1 <= qte_pkg::mulq(s_in, s_in);
      w1   <= wprod[62:32];

      s2   <= s1;
      e2   <= e1;
      s3_2 <= qte_pkg::mulq(s2_1, s1);
      w2_2 <= wsq[60:33];

      s3   <= s2;
      e3   <= e2;
      s4_3 <= qte_pkg::mulq(s3_2, s2);
      s3_3 <= s3_2;
      g3   <= 32'(w2_2) * 32'd30;

      e4   <= e3;
      s3_4 <= s3_3;
      s4_4 <= s4_3;
      s5_4 <= qte_pkg::mulq(s4_3, s3);
      g4   <= g3;

      // blend polynomial, clamped; end of motion forces h = 1, g = 0
      if (e4 || hs_over) begin
        h5 <= qte_pkg::H_ONE;
      end else if (hs[37]) begin
        h5 <= '0;
      end else begin
        h5 <= hs[32:0];
      end
      g5 <= e4 ? 32'd0 : g4;
    end
  end

  assign ctl_out = c5;
  assign h       = h5;
  assign g       = g5;

endmodule

>>> hdl/qte_axis.sv
`timescale 1ns / 1ps

module qte_axis (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  qte_pkg::ctl_t  ctl_in,
  input  logic [32:0]    h,
  input  logic [31:0]    g,
  input  logic [31:0]    dur,
  input  logic [31:0]    start,
  input  logic [31:0]    fin,
  output qte_pkg::ctl_t  ctl_out,
  output logic [31:0]    pos,
  output logic [47:0]    vel
);

  localparam int N  = qte_pkg::VDIV_STAGES;
  localparam int DW = qte_pkg::VDIV_W;

  logic [32:0]    delta;
  logic           neg;
  logic [31:0]    mag;

  qte_pkg::ctl_t  c1;
  logic [31:0]    st1;
  logic           ng1;
  logic [64:0]    ph1;
  logic [63:0]    pg1;
  logic [64:0]    phr;
  logic [31:0]    pm;

  qte_pkg::ctl_t  dc   [0:N];
  logic           dng  [0:N];
  logic [31:0]    dpos [0:N];
  logic [DW-1:0]  num  [0:N];
  logic [DW-1:0]  quo  [0:N];
  logic [31:0]    rem  [0:N];
  qte_pkg::div2_t step [0:N-1];

  qte_pkg::ctl_t  cf;
  logic [31:0]    posf;
  logic [47:0]    velf;
  logic           big;

  // span magnitude and sign
  always_comb begin
    delta = {fin[31], fin} - {start[31], start};
    neg   = delta[32];
    mag   = neg ? 32'(~delta + 33'd1) : delta[31:0];
    phr   = ph1 + 65'h8000_0000;
    pm    = phr[63:32];
    for (int k = 0; k < N; k++) begin
      step[k] = qte_pkg::div_step2(rem[k], num[k][DW-1 -: 2], dur);
    end
    big = quo[N] > DW'(qte_pkg::VEL_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      cf <= '0;
      for (int k = 0; k <= N; k++) begin
        dc[k] <= '0;
      end
    end else if (en) begin
      c1    <= ctl_in;
      dc[0] <= c1;
      for (int k = 0; k < N; k++) begin
        dc[k+1] <= dc[k];
      end
      cf <= dc[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products with blend and its slope
      st1 <= start;
      ng1 <= neg;
      ph1 <= 65'(mag) * 65'(h);
      pg1 <= 64'(mag) * 64'(g);

      // position, and velocity numerator into the divider
      dng[0]  <= ng1;
      dpos[0] <= ng1 ? st1 - pm : st1 + pm;
      num[0]  <= DW'(pg1 >> qte_pkg::VSHIFT);
      quo[0]  <= '0;
      rem[0]  <= '0;
      for (int k = 0; k < N; k++) begin
        dng[k+1]  <= dng[k];
        dpos[k+1] <= dpos[k];
        num[k+1]  <= num[k] << 2;
        quo[k+1]  <= {quo[k][DW-3:0], step[k].q};
        rem[k+1]  <= step[k].rem;
      end

      // sign and saturate
      posf <= dpos[N];
      if (dng[N]) begin
        velf <= big ? qte_pkg::VEL_MIN : 48'(~quo[N] + DW'(1));
      end else begin
        velf <= big ? qte_pkg::VEL_MAX : quo[N][47:0];
      end
    end
  end

  assign ctl_out = cf;
  assign pos     = posf;
  assign vel     = velf;

endmodule

>>> hdl/quintic_trajectory_evaluator_core.sv
`timescale 1ns / 1ps

// Quintic rest-to-rest trajectory evaluator. Each request on the slave stream
// carries a time in ticks and returns one point of the move: x, y, z position
// and rotation angle (Q16.16) plus their rates per tick (Q16.32), with
// tuser set when the time lay past the duration and was clamped to the end.
// A new request is taken every cycle while the skid stage is free. The pipeline
// holds two long dividers (time over duration, and each rate over duration),
// each retiring two quotient bits per pipeline stage. A duration of zero acts as
// one tick. Registers are meant to be written while no request is in flight.
module quintic_trajectory_evaluator_core (
  input  logic          clk,
  input  logic          rst,
  // configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  // time in
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // time_now
  // trajectory point out
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // pos_x, pos_y, pos_z, angle_now, vel_x, vel_y, vel_z, angle_rate, zero pad
  output logic [311:0]  m_axis_tdata,
  output logic          m_axis_tuser    // past_end
);

  logic [31:0]   x_start, x_end, y_start, y_end, z_start, z_end, duration;
  logic [17:0]   angle_total;
  logic [31:0]   dur_m, dur_eff, t_m;

  logic          en;
  qte_pkg::ctl_t ph_ctl, po_ctl, ax_ctl;
  logic [31:0]   ph_s;
  logic          ph_end;
  logic [32:0]   po_h;
  logic [31:0]   po_g;
  logic [31:0]   pos_x, pos_y, pos_z, pos_a;
  logic [47:0]   vel_x, vel_y, vel_z, vel_a;

  logic [311:0]  p_data;
  logic          push, take;
  logic          skid_valid;
  logic [311:0]  skid_data;
  logic          skid_user;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_start     <= '0;
      x_end       <= '0;
      y_start     <= '0;
      y_end       <= '0;
      z_start     <= '0;
      z_end       <= '0;
      angle_total <= '0;
      duration    <= 32'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (qte_pkg::reg_idx_t'(cfg_index))
        qte_pkg::REG_X_START:     x_start     <= cfg_data;
        qte_pkg::REG_X_END:       x_end       <= cfg_data;
        qte_pkg::REG_Y_START:     y_start     <= cfg_data;
        qte_pkg::REG_Y_END:       y_end       <= cfg_data;
        qte_pkg::REG_Z_START:     z_start     <= cfg_data;
        qte_pkg::REG_Z_END:       z_end       <= cfg_data;
        qte_pkg::REG_ANGLE_TOTAL: angle_total <= cfg_data[17:0];
        qte_pkg::REG_DURATION:    duration    <= cfg_data;
        default: ;
      endcase
    end
  end

  // masked time and duration, zero duration acts as one tick
  assign dur_m   = duration & qte_pkg::TIME_MASK;
  assign dur_eff = (dur_m == 32'd0) ? 32'd1 : dur_m;
  assign t_m     = s_axis_tdata & qte_pkg::TIME_MASK;

  // pipeline runs while the skid stage is free
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  qte_phase u_phase (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .t        (t_m),
    .dur      (dur_eff),
    .ctl_out  (ph_ctl),
    .s        (ph_s),
    .at_end   (ph_end)
  );

  qte_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl_in    (ph_ctl),
    .s_in      (ph_s),
    .at_end_in (ph_end),
    .ctl_out   (po_ctl),
    .h         (po_h),
    .g         (po_g)
  );

  qte_axis u_axis_x (
    .clk (clk), .rst (rst), .en (en), .ctl_in (po_ctl), .h (po_h), .g (po_g),
    .dur (dur_eff), .start (x_start), .fin (x_end),
    .ctl_out (ax_ctl), .pos (pos_x), .vel (vel_x)
  );

  qte_axis u_axis_y (
    .clk (clk), .rst (rst), .en (en), .ctl_in (po_ctl), .h (po_h), .g (po_g),
    .dur (dur_eff), .start (y_start), .fin (y_end),
    .ctl_out (), .pos (pos_y), .vel (vel_y)
  );

  qte_axis u_axis_z (
    .clk (clk), .rst (rst), .en (en), .ctl_in (po_ctl), .h (po_h), .g (po_g),
    .dur (dur_eff), .start (z_start), .fin (z_end),
    .ctl_out (), .pos (pos_z), .vel (vel_z)
  );

  qte_axis u_axis_a (
    .clk (clk), .rst (rst), .en (en), .ctl_in (po_ctl), .h (po_h), .g (po_g),
    .dur (dur_eff), .start (32'd0), .fin ({14'd0, angle_total}),
    .ctl_out (), .pos (pos_a), .vel (vel_a)
  );

  assign p_data = {6'd0, vel_a, vel_z, vel_y, vel_x, pos_a[17:0], pos_z, pos_y, pos_x};
  assign push   = en && ax_ctl.valid;
  assign take   = m_axis_tvalid && m_axis_tready;

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (push) begin
      if (!m_axis_tvalid || take) begin
        m_axis_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!m_axis_tvalid || take) begin
        m_axis_tdata <= p_data;
        m_axis_tuser <= ax_ctl.past;
      end else begin
        skid_data <= p_data;
        skid_user <= ax_ctl.past;
      end
    end else if (take && skid_valid) begin
      m_axis_tdata <= skid_data;
      m_axis_tuser <= skid_user;
    end
  end

  // skid holds a result only behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid stage full with output register empty");

  // a parked result is never overwritten
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && $past(skid_valid) |-> $stable(skid_data) && $stable(skid_user))
    else $error("skid stage changed while full");

  // clamped time means the move is at rest
  a_rest_past_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[305:114] == '0)
    else $error("nonzero rate after end of motion");

endmodule

>>> tb/sv/quintic_trajectory_evaluator_core_tb.sv
`timescale 1ns / 1ps

module quintic_trajectory_evaluator_core_tb;

  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 1000;

  // one trajectory point as seen on the output stream
  typedef struct {
    logic [31:0] pos_x, pos_y, pos_z;
    logic [17:0] angle_now;
    logic [47:0] vel_x, vel_y, vel_z, angle_rate;
    logic        past_end;
  } point_t;

  // keeps the register copy, predicts points and checks them in order
  class point_scoreboard;
    logic [31:0] regs [8];
    point_t      expected_points [$];
    int          mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[qte_pkg::REG_DURATION] = 32'd1000;
      mismatches = 0;
    endfunction

    function void set_reg(qte_pkg::reg_idx_t idx, logic [31:0] v);
      if (idx == qte_pkg::REG_ANGLE_TOTAL) regs[idx] = v & 32'h3FFFF;
      else regs[idx] = v;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      return (a * b + 64'h8000_0000) >> 32;
    endfunction

    // one axis: position from the blend, rate from its derivative
    function void eval_axis(logic signed [63:0] start, logic signed [63:0] delta,
                            logic [63:0] h, logic [63:0] g, logic [63:0] dur,
                            output logic [63:0] pos, output logic [47:0] vel);
      logic        neg;
      logic [63:0] mag, pm, vm;
      neg = delta < 0;
      mag = neg ? -delta : delta;
      pm  = (mag * h + 64'h8000_0000) >> 32;
      vm  = ((mag * g) >> qte_pkg::VSHIFT) / dur;
      pos = neg ? start - $signed(pm) : start + $signed(pm);
      if (vm > 64'(qte_pkg::VEL_MAX)) vel = neg ? qte_pkg::VEL_MIN : qte_pkg::VEL_MAX;
      else vel = neg ? 48'(-vm) : vm[47:0];
    endfunction

    function void note_input(logic [31:0] t);
      logic [63:0]        tt, dur, s, s2, s3, s4, s5, w, w2, h, g, pos;
      logic [95:0]        num;
      logic signed [63:0] hs, st, en;
      logic [47:0]        vel;
      point_t             e;
      tt = 64'(t & qte_pkg::TIME_MASK);
      dur = 64'(regs[qte_pkg::REG_DURATION] & qte_pkg::TIME_MASK);
      if (dur == 0) dur = 1;
      e.past_end = tt > dur;
      if (tt >= dur) begin
        h = 64'h1_0000_0000;
        g = 0;
      end else begin
        num = {tt[31:0], 32'd0};
        s = 64'(num / 96'(dur));
        s2 = qmul(s, s);
        s3 = qmul(s2, s);
        s4 = qmul(s3, s);
        s5 = qmul(s4, s);
        hs = 64'sd10 * $signed(s3) - 64'sd15 * $signed(s4) + 64'sd6 * $signed(s5);
        if (hs < 0) hs = 0;
        if (hs > 64'sh1_0000_0000) hs = 64'sh1_0000_0000;
        h = hs;
        w = (s * (64'h1_0000_0000 - s) + 64'h8000_0000) >> 32;
        w2 = (w * w + 64'h1_0000_0000) >> 33;
        g = 30 * w2;
      end
      st = $signed(regs[qte_pkg::REG_X_START]); en = $signed(regs[qte_pkg::REG_X_END]);
      eval_axis(st, en - st, h, g, dur, pos, vel);
      e.pos_x = pos[31:0]; e.vel_x = vel;
      st = $signed(regs[qte_pkg::REG_Y_START]); en = $signed(regs[qte_pkg::REG_Y_END]);
      eval_axis(st, en - st, h, g, dur, pos, vel);
      e.pos_y = pos[31:0]; e.vel_y = vel;
      st = $signed(regs[qte_pkg::REG_Z_START]); en = $signed(regs[qte_pkg::REG_Z_END]);
      eval_axis(st, en - st, h, g, dur, pos, vel);
      e.pos_z = pos[31:0]; e.vel_z = vel;
      eval_axis(0, 64'(regs[qte_pkg::REG_ANGLE_TOTAL]), h, g, dur, pos, vel);
      e.angle_now = pos[17:0]; e.angle_rate = vel;
      expected_points.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      mismatches++;
    endtask

    task check_result(logic [311:0] d, logic user);
      point_t e;
      if (expected_points.size() == 0) begin
        report("unexpected point", 64'(d[31:0]), 0);
        return;
      end
      e = expected_points.pop_front();
      if (d[31:0] !== e.pos_x) report("pos_x", d[31:0], e.pos_x);
      if (d[63:32] !== e.pos_y) report("pos_y", d[63:32], e.pos_y);
      if (d[95:64] !== e.pos_z) report("pos_z", d[95:64], e.pos_z);
      if (d[113:96] !== e.angle_now) report("angle_now", d[113:96], e.angle_now);
      if (d[161:114] !== e.vel_x) report("vel_x", d[161:114], e.vel_x);
      if (d[209:162] !== e.vel_y) report("vel_y", d[209:162], e.vel_y);
      if (d[257:210] !== e.vel_z) report("vel_z", d[257:210], e.vel_z);
      if (d[305:258] !== e.angle_rate) report("angle_rate", d[305:258], e.angle_rate);
      if (d[311:306] !== 6'd0) report("pad", d[311:306], 0);
      if (user !== e.past_end) report("past_end", user, e.past_end);
    endtask
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [2:0]     cfg_index = '0;
  logic [31:0]    cfg_data = '0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [31:0]    s_axis_tdata = '0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [311:0]   m_axis_tdata;
  logic           m_axis_tuser;

  point_scoreboard sb = new();
  int cycles = 0;
  int results_seen = 0;
  int recv_stall = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int items_sent = 0;
  int phase_left = 0;

  quintic_trajectory_evaluator_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // note accepted requests and check accepted points
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
      results_seen <= results_seen + 1;
    end
  end

  // receiver: random stalls, calm stretches, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 200 && phase_left >= 100) begin
      hold_done <= 1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      m_axis_tready <= 1'b0;
    end else if ((results_seen / 150) % 3 != 0 && $urandom_range(0, 5) == 0) begin
      recv_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task write_reg(qte_pkg::reg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task apply_config(logic [31:0] xs, xe, ys, ye, zs, ze, ang, dur);
    wait_idle();
    write_reg(qte_pkg::REG_X_START, xs);
    write_reg(qte_pkg::REG_X_END, xe);
    write_reg(qte_pkg::REG_Y_START, ys);
    write_reg(qte_pkg::REG_Y_END, ye);
    write_reg(qte_pkg::REG_Z_START, zs);
    write_reg(qte_pkg::REG_Z_END, ze);
    write_reg(qte_pkg::REG_ANGLE_TOTAL, ang);
    write_reg(qte_pkg::REG_DURATION, dur);
  endtask

  // offer one time request, then maybe leave a gap
  task send_time(logic [31:0] t);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if ((items_sent / 120) % 3 != 1 && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                          : $urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task idle_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  logic [31:0] dur, t;
  int n;

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: duration 1000, all axes at zero
    send_time(0); send_time(500); send_time(1000); send_time(1001);
    idle_sender();
    // full-scale moves in both directions, angle at pi
    apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h0001_0000, 32'hFFFF_0000, 32'd205887, 32'd1000);
    send_time(0); send_time(1); send_time(250); send_time(500);
    send_time(999); send_time(1000); send_time(1001); send_time(32'hFFFF_FFFF);
    idle_sender();
    // zero duration acts as one tick; angle above pi
    apply_config(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
                 32'h3FFFF, 32'd0);
    send_time(0); send_time(1); send_time(2);
    idle_sender();
    // longest duration
    apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h1234_5678, 32'h1234_5678, 32'd0, 32'hFFFF_FFFF);
    send_time(0); send_time(32'h7FFF_FFFF); send_time(32'h8000_0000);
    send_time(32'hFFFF_FFFE); send_time(32'hFFFF_FFFF);
    idle_sender();

    // random phases, each with its own setting
    n = 0;
    while (n < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: dur = $urandom_range(1, 20);
        1: dur = $urandom_range(1, 100000);
        2: dur = $urandom;
        default: dur = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom)};
      endcase
      apply_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 205887),
                   dur);
      phase_left = $urandom_range(40, 120);
      while (phase_left > 0) begin
        case ($urandom_range(0, 5))
          0: t = $urandom;
          1: t = dur + $urandom_range(0, 2) - 1;
          2: t = $urandom_range(0, 3);
          default: t = (dur > 1) ? $urandom_range(0, dur - 1) : 32'd0;
        endcase
        send_time(t);
        n++;
        phase_left--;
      end
      idle_sender();
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
